FILE: hw/rtl/qco_pkg.sv
`timescale 1ns / 1ps
package qco_pkg;

    typedef enum logic [1:0] {
        OP_QUAD_QUAD     = 2'd0,
        OP_CIRCLE_QUAD   = 2'd1,
        OP_CIRCLE_CIRCLE = 2'd2
    } t_opcode;

    // Sign of an orientation determinant.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

    localparam int HALF_W   = 16;
    localparam int RADIUS_W = 15;
    localparam int OP_W     = 2;

    // Quad edges as corner index pairs: ul-ur, ul-ll, ur-lr, ll-lr.
    localparam int EDGE_A [4] = '{0, 0, 1, 2};
    localparam int EDGE_B [4] = '{1, 2, 3, 3};

endpackage

FILE: hw/rtl/qco_orient.sv
`timescale 1ns / 1ps
module qco_orient #(
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [CW-1:0]  i_ax,
    input  logic signed [CW-1:0]  i_ay,
    input  logic signed [CW-1:0]  i_bx,
    input  logic signed [CW-1:0]  i_by,
    input  logic signed [CW-1:0]  i_cx,
    input  logic signed [CW-1:0]  i_cy,
    output qco_pkg::t_sign        o_sign
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int TW = PW + 1;

    logic signed [DW-1:0] w_d1, w_d2, w_d3, w_d4;
    logic signed [PW-1:0] w_p1, w_p2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [TW-1:0] w_t;
    qco_pkg::t_sign       n_sign, r_sign_c, r_sign_d, r_sign_e;

    assign w_d1 = DW'(i_cy) - DW'(i_ay);
    assign w_d2 = DW'(i_bx) - DW'(i_cx);
    assign w_d3 = DW'(i_cx) - DW'(i_ax);
    assign w_d4 = DW'(i_by) - DW'(i_cy);
    assign w_p1 = PW'(w_d1) * PW'(w_d2);
    assign w_p2 = PW'(w_d3) * PW'(w_d4);
    assign w_t  = TW'(r_p1) - TW'(r_p2);

    always_comb begin
        n_sign.neg  = (w_t < 0);
        n_sign.zero = (w_t == '0);
    end

    // The sign is ready after two stages; two more keep it in step with the other lanes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1     <= w_p1;
            r_p2     <= w_p2;
            r_sign_c <= n_sign;
            r_sign_d <= r_sign_c;
            r_sign_e <= r_sign_d;
        end
    end

    assign o_sign = r_sign_e;
endmodule

FILE: hw/rtl/qco_inside.sv
`timescale 1ns / 1ps
module qco_inside #(
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [CW-1:0]  i_px,
    input  logic signed [CW-1:0]  i_py,
    input  logic signed [CW-1:0]  i_qx [4],
    input  logic signed [CW-1:0]  i_qy [4],
    output logic                  o_inside
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int TW = PW + 1;
    localparam int AW = TW - 1;
    localparam int SW = AW + 2;
    // Point 0 is the tested point, points 1..4 are ul, ur, ll, lr.
    // Triangles 0 and 1 tile the quad; triangles 2..5 fan from the point.
    localparam int TRI_A [6] = '{1, 3, 0, 0, 0, 0};
    localparam int TRI_B [6] = '{2, 2, 1, 2, 3, 3};
    localparam int TRI_C [6] = '{3, 4, 2, 4, 4, 1};

    logic signed [CW-1:0] w_x [5];
    logic signed [CW-1:0] w_y [5];
    logic signed [PW-1:0] r_m1 [6];
    logic signed [PW-1:0] r_m2 [6];
    logic        [AW-1:0] r_abs [6];
    logic        [SW-1:0] w_quad, w_sum;
    logic                 r_in_d, r_in_e;

    always_comb begin
        w_x[0] = i_px;
        w_y[0] = i_py;
        for (int k = 0; k < 4; k++) begin
            w_x[k+1] = i_qx[k];
            w_y[k+1] = i_qy[k];
        end
    end

    for (genvar t = 0; t < 6; t++) begin : g_tri
        logic signed [DW-1:0] w_bx, w_by, w_cx, w_cy;
        logic signed [TW-1:0] w_cr;
        assign w_bx = DW'(w_x[TRI_B[t]]) - DW'(w_x[TRI_A[t]]);
        assign w_by = DW'(w_y[TRI_B[t]]) - DW'(w_y[TRI_A[t]]);
        assign w_cx = DW'(w_x[TRI_C[t]]) - DW'(w_x[TRI_A[t]]);
        assign w_cy = DW'(w_y[TRI_C[t]]) - DW'(w_y[TRI_A[t]]);
        assign w_cr = TW'(r_m1[t]) - TW'(r_m2[t]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m1[t]  <= PW'(w_bx) * PW'(w_cy);
                r_m2[t]  <= PW'(w_by) * PW'(w_cx);
                r_abs[t] <= (w_cr < 0) ? AW'(-w_cr) : AW'(w_cr);
            end
        end
    end

    assign w_quad = SW'(r_abs[0]) + SW'(r_abs[1]);
    assign w_sum  = SW'(r_abs[2]) + SW'(r_abs[3]) + SW'(r_abs[4]) + SW'(r_abs[5]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_d <= (w_quad == w_sum);
            r_in_e <= r_in_d;
        end
    end

    assign o_inside = r_in_e;
endmodule

FILE: hw/rtl/qco_edge.sv
`timescale 1ns / 1ps
module qco_edge #(
    parameter int CW = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [CW-1:0]            i_cx,
    input  logic signed [CW-1:0]            i_cy,
    input  logic [qco_pkg::RADIUS_W-1:0]    i_radius,
    input  logic signed [CW-1:0]            i_e1x,
    input  logic signed [CW-1:0]            i_e1y,
    input  logic signed [CW-1:0]            i_e2x,
    input  logic signed [CW-1:0]            i_e2y,
    output logic                            o_cross
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int RW = 2 * qco_pkg::RADIUS_W;
    localparam int EW = (2 * CW + 5 > 33) ? 2 * CW + 5 : 33;
    localparam int MW = 2 * CW + 2;
    localparam int HW = MW / 2;
    localparam int QW = 2 * HW;
    localparam int XW = 2 * MW;

    logic signed [DW-1:0] w_ax, w_ay, w_dx, w_dy;
    logic signed [PW-1:0] r_axax, r_ayay, r_dxdx, r_dydy, r_axdx, r_aydy;
    logic        [RW-1:0] r_rr;
    logic signed [EW-1:0] w_a, w_h, w_c;
    logic signed [EW-1:0] r_a, r_h, r_c, r_c1, r_ah;
    logic        [MW-1:0] w_mh, w_au, w_cu;
    logic        [QW-1:0] r_hh, r_hl, r_ll, r_acc_hh, r_acc_hl, r_acc_lh, r_acc_ll;
    logic                 r_azero, r_cneg, r_root;
    logic        [XW-1:0] w_sq, w_ac;
    logic                 r_cross_e;

    assign w_ax = DW'(i_e1x) - DW'(i_cx);
    assign w_ay = DW'(i_e1y) - DW'(i_cy);
    assign w_dx = DW'(i_e2x) - DW'(i_e1x);
    assign w_dy = DW'(i_e2y) - DW'(i_e1y);

    assign w_a = EW'(r_dxdx) + EW'(r_dydy);
    assign w_h = EW'(r_axdx) + EW'(r_aydy);
    assign w_c = EW'(r_axax) + EW'(r_ayay) - EW'(signed'({1'b0, r_rr}));

    assign w_mh = (r_h < 0) ? MW'(-r_h) : MW'(r_h);
    assign w_au = MW'(r_a);
    assign w_cu = MW'(r_c);

    assign w_sq = (XW'(r_hh) << (2 * HW)) + (XW'(r_hl) << (HW + 1)) + XW'(r_ll);
    assign w_ac = (XW'(r_acc_hh) << (2 * HW)) + (XW'(r_acc_hl) << HW)
                + (XW'(r_acc_lh) << HW) + XW'(r_acc_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axax <= PW'(w_ax) * PW'(w_ax);
            r_ayay <= PW'(w_ay) * PW'(w_ay);
            r_dxdx <= PW'(w_dx) * PW'(w_dx);
            r_dydy <= PW'(w_dy) * PW'(w_dy);
            r_axdx <= PW'(w_ax) * PW'(w_dx);
            r_aydy <= PW'(w_ay) * PW'(w_dy);
            r_rr   <= RW'(i_radius) * RW'(i_radius);

            r_a  <= w_a;
            r_h  <= w_h;
            r_c  <= w_c;
            r_c1 <= w_a + (w_h <<< 1) + w_c;
            r_ah <= w_a + w_h;

            // Discriminant operands are split into halves so no product exceeds HW by HW.
            r_hh     <= QW'(w_mh[MW-1:HW]) * QW'(w_mh[MW-1:HW]);
            r_hl     <= QW'(w_mh[MW-1:HW]) * QW'(w_mh[HW-1:0]);
            r_ll     <= QW'(w_mh[HW-1:0]) * QW'(w_mh[HW-1:0]);
            r_acc_hh <= QW'(w_au[MW-1:HW]) * QW'(w_cu[MW-1:HW]);
            r_acc_hl <= QW'(w_au[MW-1:HW]) * QW'(w_cu[HW-1:0]);
            r_acc_lh <= QW'(w_au[HW-1:0]) * QW'(w_cu[MW-1:HW]);
            r_acc_ll <= QW'(w_au[HW-1:0]) * QW'(w_cu[HW-1:0]);
            r_azero  <= (r_a == '0);
            r_cneg   <= (r_c < 0);
            r_root   <= (((r_h < 0) || (r_c < 0)) && (r_ah > 0) && (r_c1 > 0))
                     || ((r_h < 0) && (r_c > 0) && ((r_ah > 0) || (r_c1 < 0)));

            // A negative c means the start point is inside the circle: two real roots.
            r_cross_e <= !r_azero && (r_cneg || (w_sq > w_ac)) && r_root;
        end
    end

    assign o_cross = r_cross_e;
endmodule

FILE: hw/rtl/quad_circle_overlap_test.sv
`timescale 1ns / 1ps
// Each accepted input beat yields one result beat on the master side, in order.
// Throughput: one pair per cycle; the six register stages all advance together
// and hold while the output register is full and not taken.
// Reset: synchronous, active low; clears the valid bits of every stage, so no
// result beat appears until a new pair is accepted.
module quad_circle_overlap_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // first_upper_left, first_upper_right, first_lower_left, first_lower_right,
    // second_upper_left, second_upper_right, second_lower_left, second_lower_right,
    // circle_center, circle_radius, zero pad
    input  logic [303:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // collides, zero pad
    output logic [7:0]    m_axis_tdata,
    // unsupported
    output logic [0:0]    m_axis_tuser
);
    localparam int CW = (COORD_WIDTH > qco_pkg::HALF_W) ? qco_pkg::HALF_W : COORD_WIDTH;
    localparam int HW = qco_pkg::HALF_W;
    localparam int CE_A [4] = '{0, 0, 1, 2};
    localparam int CE_B [4] = '{2, 1, 3, 3};

    logic w_en;
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e, r_out_valid;
    qco_pkg::t_opcode r_op_a, r_op_b, r_op_c, r_op_d, r_op_e;

    logic signed [CW-1:0] r_fx [4];
    logic signed [CW-1:0] r_fy [4];
    logic signed [CW-1:0] r_sx [4];
    logic signed [CW-1:0] r_sy [4];
    logic signed [CW-1:0] r_px, r_py;
    logic [qco_pkg::RADIUS_W-1:0] r_radius;

    logic [15:0] n_box, r_box_b, r_box_c, r_box_d, r_box_e;
    qco_pkg::t_sign w_t1 [16];
    qco_pkg::t_sign w_t2 [16];
    logic [15:0] w_meet;
    logic [3:0]  w_cross;
    logic        w_in0, w_in1;
    logic        n_collides, n_unsup, r_collides, r_unsup;

    function automatic logic f_between(input logic signed [CW-1:0] v,
                                       input logic signed [CW-1:0] a,
                                       input logic signed [CW-1:0] b);
        f_between = (v >= a && v <= b) || (v <= a && v >= b);
    endfunction

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a     <= 1'b0;
            r_vld_b     <= 1'b0;
            r_vld_c     <= 1'b0;
            r_vld_d     <= 1'b0;
            r_vld_e     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld_a     <= s_axis_tvalid;
            r_vld_b     <= r_vld_a;
            r_vld_c     <= r_vld_b;
            r_vld_d     <= r_vld_c;
            r_vld_e     <= r_vld_d;
            r_out_valid <= r_vld_e;
        end
    end

    // Input stage: each coordinate is the low CW bits of its 16-bit half.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_fx[k] <= s_axis_tdata[32*k + HW +: CW];
                r_fy[k] <= s_axis_tdata[32*k +: CW];
                r_sx[k] <= s_axis_tdata[32*(k+4) + HW +: CW];
                r_sy[k] <= s_axis_tdata[32*(k+4) +: CW];
            end
            // The first containment lane tests the circle center in circle mode.
            if (qco_pkg::t_opcode'(s_axis_tuser) == qco_pkg::OP_CIRCLE_QUAD) begin
                r_px <= s_axis_tdata[256 + HW +: CW];
                r_py <= s_axis_tdata[256 +: CW];
            end else begin
                r_px <= s_axis_tdata[HW +: CW];
                r_py <= s_axis_tdata[0 +: CW];
            end
            r_radius <= s_axis_tdata[288 +: qco_pkg::RADIUS_W];
            r_op_a   <= qco_pkg::t_opcode'(s_axis_tuser);
            r_op_b   <= r_op_a;
            r_op_c   <= r_op_b;
            r_op_d   <= r_op_c;
            r_op_e   <= r_op_d;
            r_box_b  <= n_box;
            r_box_c  <= r_box_b;
            r_box_d  <= r_box_c;
            r_box_e  <= r_box_d;
        end
    end

    // Colinear overlap window for each edge pair.
    for (genvar i = 0; i < 4; i++) begin : g_box_i
        for (genvar j = 0; j < 4; j++) begin : g_box_j
            assign n_box[i*4+j] =
                (f_between(r_fx[qco_pkg::EDGE_A[i]], r_sx[qco_pkg::EDGE_A[j]],
                           r_sx[qco_pkg::EDGE_B[j]])
                 || f_between(r_fx[qco_pkg::EDGE_B[i]], r_sx[qco_pkg::EDGE_A[j]],
                              r_sx[qco_pkg::EDGE_B[j]]))
                && (f_between(r_fy[qco_pkg::EDGE_A[i]], r_sy[qco_pkg::EDGE_A[j]],
                              r_sy[qco_pkg::EDGE_B[j]])
                 || f_between(r_fy[qco_pkg::EDGE_B[i]], r_sy[qco_pkg::EDGE_A[j]],
                              r_sy[qco_pkg::EDGE_B[j]]));
        end
    end

    // Orientation of every corner against every edge of the other quad.
    for (genvar e = 0; e < 4; e++) begin : g_orient_e
        for (genvar k = 0; k < 4; k++) begin : g_orient_k
            qco_orient #(.CW(CW)) u_first (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_ax  (r_fx[qco_pkg::EDGE_A[e]]),
                .i_ay  (r_fy[qco_pkg::EDGE_A[e]]),
                .i_bx  (r_fx[qco_pkg::EDGE_B[e]]),
                .i_by  (r_fy[qco_pkg::EDGE_B[e]]),
                .i_cx  (r_sx[k]),
                .i_cy  (r_sy[k]),
                .o_sign(w_t1[e*4+k])
            );
            qco_orient #(.CW(CW)) u_second (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_ax  (r_sx[qco_pkg::EDGE_A[e]]),
                .i_ay  (r_sy[qco_pkg::EDGE_A[e]]),
                .i_bx  (r_sx[qco_pkg::EDGE_B[e]]),
                .i_by  (r_sy[qco_pkg::EDGE_B[e]]),
                .i_cx  (r_fx[k]),
                .i_cy  (r_fy[k]),
                .o_sign(w_t2[e*4+k])
            );
        end
    end

    qco_inside #(.CW(CW)) u_inside0 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_qx    (r_sx),
        .i_qy    (r_sy),
        .o_inside(w_in0)
    );

    qco_inside #(.CW(CW)) u_inside1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (r_sx[0]),
        .i_py    (r_sy[0]),
        .i_qx    (r_fx),
        .i_qy    (r_fy),
        .o_inside(w_in1)
    );

    for (genvar e = 0; e < 4; e++) begin : g_edge
        qco_edge #(.CW(CW)) u_edge (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_cx    (r_px),
            .i_cy    (r_py),
            .i_radius(r_radius),
            .i_e1x   (r_sx[CE_A[e]]),
            .i_e1y   (r_sy[CE_A[e]]),
            .i_e2x   (r_sx[CE_B[e]]),
            .i_e2y   (r_sy[CE_B[e]]),
            .o_cross (w_cross[e])
        );
    end

    for (genvar i = 0; i < 4; i++) begin : g_meet_i
        for (genvar j = 0; j < 4; j++) begin : g_meet_j
            qco_pkg::t_sign w_o1, w_o2, w_o3, w_o4;
            assign w_o1 = w_t1[i*4 + qco_pkg::EDGE_A[j]];
            assign w_o2 = w_t1[i*4 + qco_pkg::EDGE_B[j]];
            assign w_o3 = w_t2[j*4 + qco_pkg::EDGE_A[i]];
            assign w_o4 = w_t2[j*4 + qco_pkg::EDGE_B[i]];
            assign w_meet[i*4+j] = ((w_o1 != w_o2) && (w_o3 != w_o4))
                || (w_o1.zero && w_o2.zero && w_o3.zero && w_o4.zero && r_box_e[i*4+j]);
        end
    end

    always_comb begin
        n_collides = 1'b0;
        n_unsup    = 1'b0;
        case (r_op_e)
            qco_pkg::OP_QUAD_QUAD:   n_collides = (|w_meet) || w_in0 || w_in1;
            qco_pkg::OP_CIRCLE_QUAD: n_collides = w_in0 || (|w_cross);
            default:                 n_unsup    = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_collides <= n_collides;
            r_unsup    <= n_unsup;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_collides};
    assign m_axis_tuser  = r_unsup;
endmodule

FILE: sim/tb_quad_circle_overlap_test.sv
`timescale 1ns / 1ps
module tb_quad_circle_overlap_test;

    localparam int CW        = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1330;

    typedef struct packed {
        logic [1:0]   op;
        logic [303:0] data;
    } t_pair;

    typedef struct packed {
        logic hit;
        logic unsup;
    } t_verdict;

    typedef struct {
        longint x;
        longint y;
    } t_pt;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [303:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [7:0]    m_axis_tdata;
    logic [0:0]    m_axis_tuser;

    t_pair    pair_q[$];
    t_verdict verdict_q[$];
    int       n_errors = 0;
    int       n_results = 0;
    int       n_hits = 0;
    int       n_sent = 0;
    int       wdog = 0;
    int       hold_off = 0;
    int       send_gap = 0;
    bit       drain_pause = 1'b0;
    bit       stim_done = 1'b0;

    always #4 i_clk = ~i_clk;

    quad_circle_overlap_test dut (.*);

    function automatic longint sx(logic [15:0] h);
        return longint'($signed(h[CW-1:0]));
    endfunction

    function automatic t_pt unpk(logic [31:0] w);
        t_pt p;
        p.x = sx(w[31:16]);
        p.y = sx(w[15:0]);
        return p;
    endfunction

    function automatic int orient(t_pt a, t_pt b, t_pt c);
        longint v;
        v = (c.y - a.y) * (b.x - c.x) - (c.x - a.x) * (b.y - c.y);
        return v < 0 ? -1 : (v > 0 ? 1 : 0);
    endfunction

    function automatic bit in_span(longint v, longint a, longint b);
        return (v >= a && v <= b) || (v <= a && v >= b);
    endfunction

    function automatic bit segments_touch(t_pt p1, t_pt p2, t_pt q1, t_pt q2);
        int o1, o2, o3, o4;
        o1 = orient(p1, p2, q1);
        o2 = orient(p1, p2, q2);
        o3 = orient(q1, q2, p1);
        o4 = orient(q1, q2, p2);
        if (o1 != o2 && o3 != o4) return 1'b1;
        if (o1 == 0 && o2 == 0 && o3 == 0 && o4 == 0)
            return (in_span(p1.x, q1.x, q2.x) || in_span(p2.x, q1.x, q2.x)) &&
                   (in_span(p1.y, q1.y, q2.y) || in_span(p2.y, q1.y, q2.y));
        return 1'b0;
    endfunction

    function automatic longint tri2(t_pt a, t_pt b, t_pt c);
        longint v;
        v = a.x * (b.y - c.y) + b.x * (c.y - a.y) + c.x * (a.y - b.y);
        return v < 0 ? -v : v;
    endfunction

    // Corner order is ul, ur, ll, lr.
    function automatic bit point_in_quad(t_pt p, t_pt q[4]);
        longint whole, parts;
        whole = tri2(q[0], q[1], q[2]) + tri2(q[2], q[1], q[3]);
        parts = tri2(p, q[0], q[1]) + tri2(p, q[1], q[3]) +
                tri2(p, q[2], q[3]) + tri2(p, q[2], q[0]);
        return parts == whole;
    endfunction

    // Quadratic a t^2 + 2 h t + c along the edge; discriminant compared at 128 bits.
    function automatic bit edge_cuts_circle(t_pt ctr, longint r, t_pt e1, t_pt e2);
        longint ax, ay, dx, dy, a, h, c, c1;
        logic signed [127:0] hh, ac;
        bit disc, r1, r2;
        ax = e1.x - ctr.x; ay = e1.y - ctr.y;
        dx = e2.x - e1.x;  dy = e2.y - e1.y;
        a = dx * dx + dy * dy;
        h = ax * dx + ay * dy;
        c = ax * ax + ay * ay - r * r;
        c1 = a + 2 * h + c;
        if (a == 0) return 1'b0;
        hh = 128'(h) * 128'(h);
        ac = 128'(a) * 128'(c);
        disc = (c < 0) || (hh > ac);
        if (!disc) return 1'b0;
        r1 = (h < 0 || c < 0) && (a + h > 0) && c1 > 0;
        r2 = h < 0 && c > 0 && (a + h > 0 || c1 < 0);
        return r1 || r2;
    endfunction

    function automatic t_verdict overlap_verdict(t_pair it);
        t_verdict v;
        t_pt f[4], s[4], ctr;
        longint r;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            f[i] = unpk(it.data[32*i +: 32]);
            s[i] = unpk(it.data[32*(i+4) +: 32]);
        end
        ctr = unpk(it.data[256 +: 32]);
        r = longint'(it.data[288 +: 15]);
        if (it.op == qco_pkg::OP_QUAD_QUAD) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    if (segments_touch(f[qco_pkg::EDGE_A[i]], f[qco_pkg::EDGE_B[i]],
                                       s[qco_pkg::EDGE_A[j]], s[qco_pkg::EDGE_B[j]]))
                        v.hit = 1'b1;
            if (!v.hit) v.hit = point_in_quad(f[0], s) || point_in_quad(s[0], f);
        end else if (it.op == qco_pkg::OP_CIRCLE_QUAD) begin
            v.hit = point_in_quad(ctr, s) ||
                    edge_cuts_circle(ctr, r, s[0], s[2]) ||
                    edge_cuts_circle(ctr, r, s[0], s[1]) ||
                    edge_cuts_circle(ctr, r, s[1], s[3]) ||
                    edge_cuts_circle(ctr, r, s[2], s[3]);
        end else begin
            v.unsup = 1'b1;
        end
        return v;
    endfunction

    function automatic logic [31:0] pk(int x, int y);
        return {x[15:0], y[15:0]};
    endfunction

    function automatic int rgap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) :
               ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    endfunction

    // Axis-aligned box with optional corner jitter, kept near a common region.
    function automatic void make_box(ref logic [303:0] d, input int slot, input int span);
        int x0, y0, w, hgt;
        x0 = $urandom_range(0, 2 * span) - span;
        y0 = $urandom_range(0, 2 * span) - span;
        w = $urandom_range(0, span);
        hgt = $urandom_range(0, span);
        d[32*(slot+0) +: 32] = pk(x0, y0);
        d[32*(slot+1) +: 32] = pk(x0 + w, y0 + $urandom_range(0, 2));
        d[32*(slot+2) +: 32] = pk(x0 + $urandom_range(0, 2), y0 + hgt);
        d[32*(slot+3) +: 32] = pk(x0 + w, y0 + hgt);
    endfunction

    task automatic add_pair(logic [1:0] op, logic [303:0] d);
        t_pair p;
        p.op = op;
        p.data = d;
        pair_q.push_back(p);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 n_results, what, got, want);
    endtask

    // Driver: offers the oldest pending pair and retires it on acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                verdict_q.push_back(overlap_verdict(pair_q.pop_front()));
                n_sent++;
                send_gap <= rgap();
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (drain_pause && verdict_q.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if ((s_axis_tvalid && s_axis_tready) ? rgap() == 0 && pair_q.size() != 0
                         : send_gap == 0 && pair_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pair_q[0].op;
                s_axis_tdata <= pair_q[0].data;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0 && !(s_axis_tvalid && s_axis_tready)) send_gap <= send_gap - 1;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = verdict_q.pop_front();
                    n_hits += m_axis_tdata[0];
                    if (m_axis_tdata[0] !== want.hit)
                        report_mismatch("collides", m_axis_tdata[0], want.hit);
                    if (m_axis_tuser[0] !== want.unsup)
                        report_mismatch("unsupported", m_axis_tuser[0], want.unsup);
                    if (m_axis_tdata[7:1] !== 7'd0)
                        report_mismatch("pad", m_axis_tdata[7:1], 0);
                end
            end
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off <= hold_off - 1;
            end else begin
                m_axis_tready <= (rgap() == 0);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            !i_rst_n || stim_done)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", verdict_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [303:0] d;
        int n_dir;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every opcode, tangent circle, degenerate edges.
        add_pair(qco_pkg::OP_QUAD_QUAD, '0);
        add_pair(qco_pkg::OP_QUAD_QUAD, '1);
        add_pair(qco_pkg::OP_CIRCLE_QUAD, '0);
        add_pair(qco_pkg::OP_CIRCLE_QUAD, '1);
        add_pair(qco_pkg::OP_CIRCLE_CIRCLE, '1);
        add_pair(2'd3, '0);
        d = '0;
        d[0 +: 32] = pk(0, 0); d[32 +: 32] = pk(10, 0);
        d[64 +: 32] = pk(0, 10); d[96 +: 32] = pk(10, 10);
        d[128 +: 32] = pk(10, 0); d[160 +: 32] = pk(20, 0);
        d[192 +: 32] = pk(10, 10); d[224 +: 32] = pk(20, 10);
        add_pair(qco_pkg::OP_QUAD_QUAD, d);               // shared edge, colinear
        d[128 +: 32] = pk(2, 2); d[160 +: 32] = pk(4, 2);
        d[192 +: 32] = pk(2, 4); d[224 +: 32] = pk(4, 4);
        add_pair(qco_pkg::OP_QUAD_QUAD, d);               // nested quad
        d[128 +: 32] = pk(-32768, -32768); d[160 +: 32] = pk(32767, -32768);
        d[192 +: 32] = pk(-32768, 32767); d[224 +: 32] = pk(32767, 32767);
        add_pair(qco_pkg::OP_QUAD_QUAD, d);               // extreme corners
        add_pair(qco_pkg::OP_CIRCLE_QUAD, {1'b0, 15'h7fff, pk(0, 0), d[255:0]});
        d[128 +: 32] = pk(0, 0); d[160 +: 32] = pk(10, 0);
        d[192 +: 32] = pk(0, 10); d[224 +: 32] = pk(10, 10);
        add_pair(qco_pkg::OP_CIRCLE_QUAD, {1'b0, 15'd5, pk(5, -5), d[255:0]});  // tangent
        add_pair(qco_pkg::OP_CIRCLE_QUAD, {1'b0, 15'd6, pk(5, -5), d[255:0]});  // crossing
        add_pair(qco_pkg::OP_CIRCLE_QUAD, {1'b0, 15'd3, pk(5, 5), d[255:0]});   // center inside
        d[128 +: 128] = {4{pk(3, 3)}};
        add_pair(qco_pkg::OP_CIRCLE_QUAD, {1'b0, 15'd2, pk(3, 6), d[255:0]});   // degenerate
        add_pair(qco_pkg::OP_CIRCLE_QUAD, {1'b0, 15'd2, pk(30, 30), d[255:0]});
        n_dir = pair_q.size();

        for (int i = 0; i < N_RANDOM; i++) begin
            int kind, span;
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 9) == 0) ? 30000 : $urandom_range(4, 200);
            for (int k = 0; k < 9; k++) d[32*k +: 32] = $urandom();
            d[288 +: 16] = {1'b0, 15'($urandom())};
            if (kind < 7) begin
                make_box(d, 0, span);
                make_box(d, 4, span);
                d[256 +: 32] = pk($urandom_range(0, 2 * span) - span,
                                  $urandom_range(0, 2 * span) - span);
                d[288 +: 15] = ($urandom_range(0, 9) == 0) ? 15'($urandom())
                                                           : 15'($urandom_range(0, span));
            end
            add_pair(kind < 4 || kind == 8 ? qco_pkg::OP_QUAD_QUAD :
                     (kind < 7 || kind == 9 ? qco_pkg::OP_CIRCLE_QUAD
                                            : 2'($urandom_range(2, 3))), d);
            // Long receiver stall while the sender keeps offering.
            if (i == 300) wait (pair_q.size() < 40);
            if (i == 300) hold_off <= 200;
            if (i == 700) begin
                wait (pair_q.size() == 0);
                drain_pause = 1'b1;
                wait (verdict_q.size() == 0);
                drain_pause = 1'b0;
            end
        end

        wait (pair_q.size() == 0 && !s_axis_tvalid);
        wait (verdict_q.size() == 0);
        stim_done = 1'b1;
        repeat (20) @(posedge i_clk);
        $display("covered %0d directed and %0d random pairs over all opcodes", n_dir, N_RANDOM);
        $display("%0d results checked, %0d collisions seen", n_results, n_hits);
        if (n_errors == 0 && verdict_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
